/* design/dq_pkg.sv */
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants of the double-ended queue
// Opcodes, status codes, row commands and the control bundle that the
// controller broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package dq_pkg;

   // Capacity and derived widths
   localparam int DEPTH      = 128;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int WORD_W     = 32;
   localparam int OPCODE_W   = 3;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 8;

   // Command opcodes
   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_BACK  = 3'd5
   } opcode_type;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

   // What one row of cells does in a cycle
   typedef enum logic [1:0] {
      ROW_HOLD,        // keep contents
      ROW_SHIFT_UP,    // take the lower neighbor, cell 0 takes the new word
      ROW_SHIFT_DOWN,  // take the upper neighbor
      ROW_WRITE_AT     // the cell at the fill position takes the new word
   } row_op_type;

   // Broadcast from the controller to all cells
   typedef struct packed {
      row_op_type               front_op;
      row_op_type               back_op;
      logic signed [WORD_W-1:0] value;
   } cell_ctrl_type;

endpackage

/* design/dq_cell.sv */
// ----------------------------------------------------------------------------
// dq_cell: one storage cell of the queue
// Holds the i-th word counted from the front and the i-th word counted from
// the back. Each cycle either word may hold, shift from a neighbor, or take
// the new word when this cell sits at the current fill position.
// ----------------------------------------------------------------------------
module dq_cell (
   input  logic                                clock,
   input  dq_pkg::cell_ctrl_type               ctrl,
   input  logic [dq_pkg::IDX_W-1:0]            index,
   input  logic [dq_pkg::CNT_W-1:0]            occupancy,
   input  logic signed [dq_pkg::WORD_W-1:0]    front_lower,
   input  logic signed [dq_pkg::WORD_W-1:0]    front_upper,
   input  logic signed [dq_pkg::WORD_W-1:0]    back_lower,
   input  logic signed [dq_pkg::WORD_W-1:0]    back_upper,
   output logic signed [dq_pkg::WORD_W-1:0]    front_word,
   output logic signed [dq_pkg::WORD_W-1:0]    back_word
);

   logic signed [dq_pkg::WORD_W-1:0] front_ff, front_in;
   logic signed [dq_pkg::WORD_W-1:0] back_ff, back_in;
   logic                             at_fill;

   // this cell is the first unused slot of both rows
   assign at_fill = (dq_pkg::CNT_W'(index) == occupancy);

   // next value of the front-ordered word
   always_comb begin
      unique case (ctrl.front_op)
         dq_pkg::ROW_SHIFT_UP:   front_in = front_lower;
         dq_pkg::ROW_SHIFT_DOWN: front_in = front_upper;
         dq_pkg::ROW_WRITE_AT:   front_in = at_fill ? ctrl.value : front_ff;
         default:                front_in = front_ff;
      endcase
   end

   // next value of the back-ordered word
   always_comb begin
      unique case (ctrl.back_op)
         dq_pkg::ROW_SHIFT_UP:   back_in = back_lower;
         dq_pkg::ROW_SHIFT_DOWN: back_in = back_upper;
         dq_pkg::ROW_WRITE_AT:   back_in = at_fill ? ctrl.value : back_ff;
         default:                back_in = back_ff;
      endcase
   end

   // payload storage, no reset
   always_ff @(posedge clock) begin
      front_ff <= front_in;
      back_ff  <= back_in;
   end

   assign front_word = front_ff;
   assign back_word  = back_ff;

endmodule

/* design/dq_ctrl.sv */
// ----------------------------------------------------------------------------
// dq_ctrl: command decode, entry count and response register
// Turns each accepted command into row commands for the cell chain, keeps
// the occupancy and registers the one-cycle response.
// ----------------------------------------------------------------------------
module dq_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic [dq_pkg::OPCODE_W-1:0]         opcode,
   input  logic signed [dq_pkg::WORD_W-1:0]    push_value,
   input  logic signed [dq_pkg::WORD_W-1:0]    front_head,
   input  logic signed [dq_pkg::WORD_W-1:0]    back_head,
   output dq_pkg::cell_ctrl_type               cell_ctrl,
   output logic [dq_pkg::CNT_W-1:0]            occupancy,
   output logic                                rsp_strobe,
   output logic signed [dq_pkg::WORD_W-1:0]    rsp_data_out,
   output logic [dq_pkg::STATUS_W-1:0]         rsp_status,
   output logic                                rsp_empty_flag,
   output logic [dq_pkg::COUNT_W-1:0]          rsp_entry_count
);

   logic [dq_pkg::CNT_W-1:0]         occ_ff, occ_in;
   logic                             strobe_ff;
   logic signed [dq_pkg::WORD_W-1:0] data_ff, data_in;
   logic [dq_pkg::STATUS_W-1:0]      status_ff, status_in;
   logic                             empty_ff;
   logic [dq_pkg::COUNT_W-1:0]       count_ff;
   logic                             is_full;
   logic                             no_entries;

   assign is_full    = (occ_ff == dq_pkg::CNT_W'(dq_pkg::DEPTH));
   assign no_entries = (occ_ff == '0);

   // command decode
   always_comb begin
      cell_ctrl.front_op = dq_pkg::ROW_HOLD;
      cell_ctrl.back_op  = dq_pkg::ROW_HOLD;
      cell_ctrl.value    = push_value;
      occ_in             = occ_ff;
      data_in            = '0;
      status_in          = dq_pkg::ST_OK;
      if (accept) begin
         unique case (opcode)
            dq_pkg::OP_PUSH_FRONT: begin
               if (is_full) begin
                  status_in = dq_pkg::ST_OVERFLOW;
               end else begin
                  cell_ctrl.front_op = dq_pkg::ROW_SHIFT_UP;
                  cell_ctrl.back_op  = dq_pkg::ROW_WRITE_AT;
                  occ_in             = occ_ff + dq_pkg::CNT_W'(1);
               end
            end
            dq_pkg::OP_PUSH_BACK: begin
               if (is_full) begin
                  status_in = dq_pkg::ST_OVERFLOW;
               end else begin
                  cell_ctrl.front_op = dq_pkg::ROW_WRITE_AT;
                  cell_ctrl.back_op  = dq_pkg::ROW_SHIFT_UP;
                  occ_in             = occ_ff + dq_pkg::CNT_W'(1);
               end
            end
            dq_pkg::OP_POP_FRONT: begin
               if (no_entries) begin
                  data_in   = '1;
                  status_in = dq_pkg::ST_EMPTY;
               end else begin
                  data_in            = front_head;
                  cell_ctrl.front_op = dq_pkg::ROW_SHIFT_DOWN;
                  occ_in             = occ_ff - dq_pkg::CNT_W'(1);
               end
            end
            dq_pkg::OP_POP_BACK: begin
               if (no_entries) begin
                  data_in   = '1;
                  status_in = dq_pkg::ST_EMPTY;
               end else begin
                  data_in           = back_head;
                  cell_ctrl.back_op = dq_pkg::ROW_SHIFT_DOWN;
                  occ_in            = occ_ff - dq_pkg::CNT_W'(1);
               end
            end
            dq_pkg::OP_PEEK_FRONT: begin
               if (no_entries) begin
                  data_in   = '1;
                  status_in = dq_pkg::ST_EMPTY;
               end else begin
                  data_in = front_head;
               end
            end
            dq_pkg::OP_PEEK_BACK: begin
               if (no_entries) begin
                  data_in   = '1;
                  status_in = dq_pkg::ST_EMPTY;
               end else begin
                  data_in = back_head;
               end
            end
            default: begin
               // unused opcodes: no operation, plain ok response
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         occ_ff    <= occ_in;
         strobe_ff <= accept;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      data_ff   <= data_in;
      status_ff <= status_in;
      empty_ff  <= (occ_in == '0);
      count_ff  <= dq_pkg::COUNT_W'(occ_in);
   end

   assign occupancy       = occ_ff;
   assign rsp_strobe      = strobe_ff;
   assign rsp_data_out    = data_ff;
   assign rsp_status      = status_ff;
   assign rsp_empty_flag  = empty_ff;
   assign rsp_entry_count = count_ff;

endmodule

/* design/double_ended_queue.sv */
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed 32-bit words
// Push/pop/peek at either end, one response per command.
// ----------------------------------------------------------------------------
// Takes one command in every clock cycle (busy stays low) and answers each
// with exactly one response, strobed on rsp_strobe for a single cycle in the
// cycle after the command; the receiver cannot stall, so it must take every
// response in that cycle. Storage is a chain of DEPTH cells, each holding the
// word at its distance from the front and the word at its distance from the
// back, so both ends are always read at the first cell and every operation
// is a single shift or fill-position write along the chain. Pop or peek
// on an empty queue answers -1 with status empty; a push into a full queue
// answers status overflow and changes nothing. No clearing pass after reset.
// ----------------------------------------------------------------------------
module double_ended_queue (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [dq_pkg::OPCODE_W-1:0]         req_opcode,
   input  logic signed [dq_pkg::WORD_W-1:0]    req_push_value,
   output logic                                rsp_strobe,
   output logic signed [dq_pkg::WORD_W-1:0]    rsp_data_out,
   output logic [dq_pkg::STATUS_W-1:0]         rsp_status,
   output logic                                rsp_empty_flag,
   output logic [dq_pkg::COUNT_W-1:0]          rsp_entry_count
);

   dq_pkg::cell_ctrl_type            cell_ctrl;
   logic [dq_pkg::CNT_W-1:0]         occupancy;
   logic                             accept;
   logic signed [dq_pkg::WORD_W-1:0] front_word [dq_pkg::DEPTH];
   logic signed [dq_pkg::WORD_W-1:0] back_word  [dq_pkg::DEPTH];

   // busy is tied low: no command ever waits
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // decode, count and response
   dq_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .opcode          (req_opcode),
      .push_value      (req_push_value),
      .front_head      (front_word[0]),
      .back_head       (back_word[0]),
      .cell_ctrl       (cell_ctrl),
      .occupancy       (occupancy),
      .rsp_strobe      (rsp_strobe),
      .rsp_data_out    (rsp_data_out),
      .rsp_status      (rsp_status),
      .rsp_empty_flag  (rsp_empty_flag),
      .rsp_entry_count (rsp_entry_count)
   );

   // cell chain; cell 0 takes new words on a shift up
   for (genvar i = 0; i < dq_pkg::DEPTH; i++) begin : g_cell
      logic signed [dq_pkg::WORD_W-1:0] front_lower, front_upper;
      logic signed [dq_pkg::WORD_W-1:0] back_lower, back_upper;

      if (i == 0) begin : g_first
         assign front_lower = cell_ctrl.value;
         assign back_lower  = cell_ctrl.value;
      end else begin : g_inner_lo
         assign front_lower = front_word[i-1];
         assign back_lower  = back_word[i-1];
      end

      if (i == dq_pkg::DEPTH - 1) begin : g_last
         assign front_upper = '0;
         assign back_upper  = '0;
      end else begin : g_inner_hi
         assign front_upper = front_word[i+1];
         assign back_upper  = back_word[i+1];
      end

      dq_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .index       (dq_pkg::IDX_W'(i)),
         .occupancy   (occupancy),
         .front_lower (front_lower),
         .front_upper (front_upper),
         .back_lower  (back_lower),
         .back_upper  (back_upper),
         .front_word  (front_word[i]),
         .back_word   (back_word[i])
      );
   end

endmodule

/* design/dq_checker.sv */
// ----------------------------------------------------------------------------
// dq_checker: port-level checks of the double-ended queue
// Watches the command and response ports and flags inconsistent responses.
// ----------------------------------------------------------------------------
module dq_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic                                rsp_strobe,
   input logic signed [dq_pkg::WORD_W-1:0]    rsp_data_out,
   input logic [dq_pkg::STATUS_W-1:0]         rsp_status,
   input logic                                rsp_empty_flag,
   input logic [dq_pkg::COUNT_W-1:0]          rsp_entry_count
);

   // one response per transaction, in the following cycle
   a_one_response: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (rsp_strobe == $past(start && !busy)))
      else $error("response strobe does not follow the accepted transaction");

   // empty flag agrees with the count
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_empty_flag == (rsp_entry_count == '0)))
      else $error("empty flag and entry count disagree");

   // an empty response carries -1 and an empty queue
   a_empty_resp: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == dq_pkg::ST_EMPTY) |->
         (rsp_data_out == -32'sd1 && rsp_empty_flag))
      else $error("empty status with data or nonzero count");

   // overflow only when full
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == dq_pkg::ST_OVERFLOW) |->
         (rsp_entry_count == dq_pkg::COUNT_W'(dq_pkg::DEPTH) && rsp_data_out == '0))
      else $error("overflow reported while not full");

   // back-to-back responses move the count by at most one
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(rsp_strobe) && !$past(reset)) |->
         (rsp_entry_count == $past(rsp_entry_count) ||
          rsp_entry_count == $past(rsp_entry_count) + 8'd1 ||
          rsp_entry_count == $past(rsp_entry_count) - 8'd1))
      else $error("entry count jumped by more than one");

endmodule

bind double_ended_queue dq_checker u_dq_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the double-ended queue
// Drives push, pop, peek and unused opcodes through the start/busy command
// port. A cycle-free deque model predicts the untyped responses, and a monitor
// compares each strobed response field by field in order. A short directed
// table covers empty and extreme cases. Random segments then fill the deque
// to overflow, drain it to empty and mix both ends so the pointers wrap.
// ----------------------------------------------------------------------------
module testbench;

   // Opcodes the block treats as no operation
   localparam logic [dq_pkg::OPCODE_W-1:0] OP_NOP_LOW  = 3'd6;
   localparam logic [dq_pkg::OPCODE_W-1:0] OP_NOP_HIGH = 3'd7;

   // Random segment flavors
   localparam int MODE_FILL    = 0;
   localparam int MODE_DRAIN   = 1;
   localparam int MODE_MIXED   = 2;

   localparam int RANDOM_ITEMS = 1400;

   typedef struct packed {
      logic signed [dq_pkg::WORD_W-1:0] data;
      logic [dq_pkg::STATUS_W-1:0]      status;
      logic                             empty;
      logic [dq_pkg::COUNT_W-1:0]       count;
   } deque_result_type;

   typedef struct packed {
      logic [dq_pkg::OPCODE_W-1:0]      op;
      logic signed [dq_pkg::WORD_W-1:0] val;
      logic                             typed;
      deque_result_type                 exp;
   } stim_row_type;

   logic                               clock;
   logic                               reset          = 1'b1;
   logic                               start          = 1'b0;
   logic                               busy;
   logic [dq_pkg::OPCODE_W-1:0]        req_opcode     = '0;
   logic signed [dq_pkg::WORD_W-1:0]   req_push_value = '0;
   logic                               rsp_strobe;
   logic signed [dq_pkg::WORD_W-1:0]   rsp_data_out;
   logic [dq_pkg::STATUS_W-1:0]        rsp_status;
   logic                               rsp_empty_flag;
   logic [dq_pkg::COUNT_W-1:0]         rsp_entry_count;

   // Shadow deque state
   logic signed [dq_pkg::WORD_W-1:0]   shadow_store [dq_pkg::DEPTH];
   logic [dq_pkg::IDX_W-1:0]           front_idx;
   logic [dq_pkg::IDX_W-1:0]           back_idx;
   int unsigned                        fill_level;

   deque_result_type                   pending_results [$];
   stim_row_type                       directed_rows [$];

   int                                 mismatch_count;
   int                                 sent_count;
   int                                 checked_count;
   int                                 overflow_seen;
   int                                 empty_seen;
   int                                 peak_count;

   double_ended_queue uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_push_value  (req_push_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_data_out    (rsp_data_out),
      .rsp_status      (rsp_status),
      .rsp_empty_flag  (rsp_empty_flag),
      .rsp_entry_count (rsp_entry_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Run limit, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

   // One line per mismatch
   task automatic flag_mismatch(input string msg);
      $display("tb: mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   function automatic logic [dq_pkg::IDX_W-1:0] wrap_next(input logic [dq_pkg::IDX_W-1:0] i);
      return (i == dq_pkg::IDX_W'(dq_pkg::DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [dq_pkg::IDX_W-1:0] wrap_prev(input logic [dq_pkg::IDX_W-1:0] i);
      return (i == '0) ? dq_pkg::IDX_W'(dq_pkg::DEPTH - 1) : i - 1'b1;
   endfunction

   // Apply one command to the shadow deque and return its response
   function automatic deque_result_type apply_deque_op(
         input logic [dq_pkg::OPCODE_W-1:0] op,
         input logic signed [dq_pkg::WORD_W-1:0] val);
      deque_result_type r;
      r.data   = '0;
      r.status = dq_pkg::ST_OK;
      case (op)
         dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
            if (fill_level >= dq_pkg::DEPTH) begin
               r.status = dq_pkg::ST_OVERFLOW;
            end else if (op == dq_pkg::OP_PUSH_FRONT) begin
               front_idx = wrap_prev(front_idx);
               shadow_store[front_idx] = val;
               fill_level++;
            end else begin
               shadow_store[back_idx] = val;
               back_idx = wrap_next(back_idx);
               fill_level++;
            end
         end
         dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK,
         dq_pkg::OP_PEEK_FRONT, dq_pkg::OP_PEEK_BACK: begin
            if (fill_level == 0) begin
               r.data   = -32'sd1;
               r.status = dq_pkg::ST_EMPTY;
            end else if (op == dq_pkg::OP_POP_FRONT) begin
               r.data    = shadow_store[front_idx];
               front_idx = wrap_next(front_idx);
               fill_level--;
            end else if (op == dq_pkg::OP_POP_BACK) begin
               back_idx = wrap_prev(back_idx);
               r.data   = shadow_store[back_idx];
               fill_level--;
            end else if (op == dq_pkg::OP_PEEK_FRONT) begin
               r.data = shadow_store[front_idx];
            end else begin
               r.data = shadow_store[wrap_prev(back_idx)];
            end
         end
         default: ;
      endcase
      r.empty = (fill_level == 0);
      r.count = fill_level[dq_pkg::COUNT_W-1:0];
      return r;
   endfunction

   // Issue one command, hold it until taken, then drop start and idle when gap is nonzero
   task automatic issue_op(input logic [dq_pkg::OPCODE_W-1:0] op,
                           input logic signed [dq_pkg::WORD_W-1:0] val,
                           input logic typed, input deque_result_type typed_exp,
                           input int gap);
      deque_result_type pred;
      req_opcode     <= op;
      req_push_value <= val;
      start          <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      pred = apply_deque_op(op, val);
      pending_results = {pending_results, (typed ? typed_exp : pred)};
      sent_count++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic int pick_gap(input bit no_idle);
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 65)
         return 0;
      else if (r < 94)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   function automatic logic [dq_pkg::OPCODE_W-1:0] pick_opcode(input int mode);
      int r;
      r = $urandom_range(0, 99);
      if (r < 3)
         return ($urandom_range(0, 1) != 0) ? OP_NOP_HIGH : OP_NOP_LOW;
      case (mode)
         MODE_FILL:  r = (r < 80) ? 0 : 1;
         MODE_DRAIN: r = (r < 80) ? 1 : 0;
         default:    r = (r < 50) ? 0 : 1;
      endcase
      if (r == 0)
         return ($urandom_range(0, 1) != 0) ? dq_pkg::OP_PUSH_BACK : dq_pkg::OP_PUSH_FRONT;
      case ($urandom_range(0, 3))
         0:       return dq_pkg::OP_POP_FRONT;
         1:       return dq_pkg::OP_POP_BACK;
         2:       return dq_pkg::OP_PEEK_FRONT;
         default: return dq_pkg::OP_PEEK_BACK;
      endcase
   endfunction

   function automatic logic signed [dq_pkg::WORD_W-1:0] pick_value();
      case ($urandom_range(0, 19))
         0:       return 32'sh7fff_ffff;
         1:       return 32'sh8000_0000;
         2:       return -32'sd1;
         3:       return 32'sd0;
         default: return $urandom;
      endcase
   endfunction

   function automatic stim_row_type make_row(input logic [dq_pkg::OPCODE_W-1:0] op,
                                             input logic signed [dq_pkg::WORD_W-1:0] val,
                                             input logic typed,
                                             input logic signed [dq_pkg::WORD_W-1:0] data,
                                             input logic [dq_pkg::STATUS_W-1:0] status,
                                             input logic empty,
                                             input logic [dq_pkg::COUNT_W-1:0] count);
      stim_row_type row;
      row.op         = op;
      row.val        = val;
      row.typed      = typed;
      row.exp.data   = data;
      row.exp.status = status;
      row.exp.empty  = empty;
      row.exp.count  = count;
      return row;
   endfunction

   // Append one row to the directed table
   task automatic add_row(input stim_row_type row);
      directed_rows = {directed_rows, row};
   endtask

   // Response checker: every strobe must match the oldest expectation
   always @(posedge clock) begin
      deque_result_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_results.size() == 0) begin
            flag_mismatch("response with no transaction outstanding");
         end else begin
            want = pending_results[0];
            pending_results.delete(0);
            checked_count++;
            if (rsp_data_out !== want.data)
               flag_mismatch($sformatf("data_out %0h, expected %0h", rsp_data_out, want.data));
            if (rsp_status !== want.status)
               flag_mismatch($sformatf("status %0d, expected %0d", rsp_status, want.status));
            if (rsp_empty_flag !== want.empty)
               flag_mismatch($sformatf("empty_flag %b, expected %b",
                                       rsp_empty_flag, want.empty));
            if (rsp_entry_count !== want.count)
               flag_mismatch($sformatf("entry_count %0d, expected %0d",
                                       rsp_entry_count, want.count));
            if (want.status == dq_pkg::ST_OVERFLOW) overflow_seen++;
            if (want.status == dq_pkg::ST_EMPTY) empty_seen++;
            if (int'(want.count) > peak_count) peak_count = want.count;
         end
      end
   end

   // Stimulus and end of run
   initial begin
      int                mode;
      int                seg_len;
      int                total_items;
      bit                no_idle;
      int                wait_cycles;
      deque_result_type  unused_exp;

      mismatch_count = 0;
      sent_count     = 0;
      checked_count  = 0;
      overflow_seen  = 0;
      empty_seen     = 0;
      peak_count     = 0;
      front_idx      = '0;
      back_idx       = '0;
      fill_level     = 0;
      unused_exp     = '0;

      // Directed table: empty queue, unused opcodes, word extremes, both ends
      add_row(make_row(dq_pkg::OP_POP_FRONT, '0, 1'b1, -32'sd1, dq_pkg::ST_EMPTY, 1'b1, 8'd0));
      add_row(make_row(dq_pkg::OP_POP_BACK, '0, 1'b1, -32'sd1, dq_pkg::ST_EMPTY, 1'b1, 8'd0));
      add_row(make_row(dq_pkg::OP_PEEK_FRONT, '0, 1'b1, -32'sd1, dq_pkg::ST_EMPTY, 1'b1, 8'd0));
      add_row(make_row(dq_pkg::OP_PEEK_BACK, '0, 1'b1, -32'sd1, dq_pkg::ST_EMPTY, 1'b1, 8'd0));
      add_row(make_row(OP_NOP_LOW, -32'sd1, 1'b1, 32'sd0, dq_pkg::ST_OK, 1'b1, 8'd0));
      add_row(make_row(OP_NOP_HIGH, -32'sd1, 1'b1, 32'sd0, dq_pkg::ST_OK, 1'b1, 8'd0));
      add_row(make_row(dq_pkg::OP_PUSH_FRONT, 32'sh7fff_ffff, 1'b1, 32'sd0, dq_pkg::ST_OK,
                       1'b0, 8'd1));
      add_row(make_row(dq_pkg::OP_PUSH_BACK, 32'sh8000_0000, 1'b1, 32'sd0, dq_pkg::ST_OK,
                       1'b0, 8'd2));
      add_row(make_row(dq_pkg::OP_PEEK_FRONT, '0, 1'b1, 32'sh7fff_ffff, dq_pkg::ST_OK,
                       1'b0, 8'd2));
      add_row(make_row(dq_pkg::OP_PEEK_BACK, '0, 1'b1, 32'sh8000_0000, dq_pkg::ST_OK,
                       1'b0, 8'd2));
      add_row(make_row(dq_pkg::OP_PUSH_FRONT, -32'sd1, 1'b0, '0, dq_pkg::ST_OK, 1'b0, '0));
      add_row(make_row(dq_pkg::OP_PUSH_BACK, 32'sd0, 1'b0, '0, dq_pkg::ST_OK, 1'b0, '0));
      add_row(make_row(dq_pkg::OP_PUSH_FRONT, 32'sd1, 1'b0, '0, dq_pkg::ST_OK, 1'b0, '0));
      add_row(make_row(dq_pkg::OP_PEEK_FRONT, '0, 1'b0, '0, dq_pkg::ST_OK, 1'b0, '0));
      add_row(make_row(OP_NOP_LOW, 32'sd5, 1'b0, '0, dq_pkg::ST_OK, 1'b0, '0));
      add_row(make_row(dq_pkg::OP_POP_BACK, '0, 1'b0, '0, dq_pkg::ST_OK, 1'b0, '0));
      add_row(make_row(dq_pkg::OP_POP_BACK, '0, 1'b0, '0, dq_pkg::ST_OK, 1'b0, '0));
      add_row(make_row(dq_pkg::OP_POP_FRONT, '0, 1'b0, '0, dq_pkg::ST_OK, 1'b0, '0));
      add_row(make_row(dq_pkg::OP_POP_FRONT, '0, 1'b0, '0, dq_pkg::ST_OK, 1'b0, '0));
      add_row(make_row(dq_pkg::OP_POP_BACK, '0, 1'b0, '0, dq_pkg::ST_OK, 1'b0, '0));
      add_row(make_row(dq_pkg::OP_POP_BACK, '0, 1'b1, -32'sd1, dq_pkg::ST_EMPTY, 1'b1, 8'd0));
      add_row(make_row(dq_pkg::OP_PUSH_BACK, 32'sh5555_5555, 1'b0, '0, dq_pkg::ST_OK,
                       1'b0, '0));
      add_row(make_row(dq_pkg::OP_PUSH_FRONT, 32'shaaaa_aaaa, 1'b0, '0, dq_pkg::ST_OK,
                       1'b0, '0));
      add_row(make_row(dq_pkg::OP_POP_FRONT, '0, 1'b0, '0, dq_pkg::ST_OK, 1'b0, '0));
      add_row(make_row(dq_pkg::OP_POP_FRONT, '0, 1'b0, '0, dq_pkg::ST_OK, 1'b0, '0));

      // Synchronous reset, then release
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         issue_op(directed_rows[i].op, directed_rows[i].val, directed_rows[i].typed,
                  directed_rows[i].exp, pick_gap(i < 12));

      // Random segments: fill toward overflow, drain toward empty, or mix
      total_items = directed_rows.size() + RANDOM_ITEMS;
      while (sent_count < total_items) begin
         mode    = $urandom_range(MODE_FILL, MODE_MIXED);
         seg_len = $urandom_range(40, 240);
         if (seg_len > total_items - sent_count)
            seg_len = total_items - sent_count;
         no_idle = ($urandom_range(0, 3) == 0);
         repeat (seg_len)
            issue_op(pick_opcode(mode), pick_value(), 1'b0, unused_exp, pick_gap(no_idle));
      end
      start <= 1'b0;

      // Drain outstanding responses, bounded
      wait_cycles = 0;
      while (pending_results.size() > 0 && wait_cycles < 200) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (4) @(posedge clock);
      if (pending_results.size() > 0)
         flag_mismatch($sformatf("%0d responses never arrived", pending_results.size()));

      $display("tb: %0d transactions sent, %0d responses checked, %0d mismatches",
               sent_count, checked_count, mismatch_count);
      $display("tb: %0d overflow and %0d empty responses, peak entry count %0d",
               overflow_seen, empty_seen, peak_count);
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
